[rtl/pllfd_pkg.sv]
package pllfd_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV1,
		ST_DIV1_WAIT,
		ST_DIV2,
		ST_DIV2_WAIT,
		ST_CHECK,
		ST_CAND_A,
		ST_CAND_A_WAIT,
		ST_CAND_B,
		ST_CAND_B_WAIT,
		ST_CAND_R1,
		ST_CAND_R2,
		ST_CAND_EVAL,
		ST_FINISH,
		ST_OUT
	} pllfd_state_t;

	typedef enum logic [2:0] {
		DOP_NONE,
		DOP_ROUND,
		DOP_TRUNC,
		DOP_BASE,
		DOP_CAND_Q,
		DOP_CAND_F
	} pllfd_dop_t;

	typedef struct packed {
		logic       load;
		pllfd_dop_t div_op;
		logic       div_start;
		logic       check;
		logic       round1;
		logic       round2;
		logic       eval;
		logic       next_cand;
		logic       finish;
	} pllfd_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic reject;
		logic exact_div;
		logic last_cand;
		logic exact_fit;
	} pllfd_sts_t;

	localparam logic [1:0]  REG_REF_RATE = 2'd0;
	localparam int unsigned ROUND_STEP = 1000;
	// ceil(2^38/125): (y*RECIP_125)>>38 == y/125 for any 32-bit y
	localparam logic [31:0] RECIP_125  = 32'd2199023256;
	localparam logic [15:0] EN_BIT     = 16'h8000;
	localparam logic [15:0] ROT_BIT    = 16'h4000;
	localparam logic [15:0] DIR_BIT    = 16'h0800;

	function automatic logic [4:0] sel_rate(input logic [1:0] sel);
		case (sel)
			2'd1:    sel_rate = 5'd16;
			2'd2:    sel_rate = 5'd8;
			2'd3:    sel_rate = 5'd4;
			default: sel_rate = 5'd0;
		endcase
	endfunction

endpackage

[rtl/pllfd_divider.sv]
module pllfd_divider import pllfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [39:0] quot,
	output logic [31:0] rem
);
	logic [5:0]  cnt_q;
	logic [39:0] q_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic [32:0] r_sh;
	logic [32:0] r_sub;

	assign r_sh  = {r_q[31:0], q_q[39]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd40;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!r_sub[32]) begin
				r_q <= r_sub;
				q_q <= {q_q[38:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[38:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = q_q;
	assign rem  = r_q[31:0];
endmodule

[rtl/pllfd_datapath.sv]
module pllfd_datapath import pllfd_pkg::*; #(
	parameter int unsigned NUM_PREDIV = 8,
	parameter int unsigned NUM_SEL    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pllfd_cmd_t  cmd,
	output pllfd_sts_t  sts,
	input  logic [31:0] ref_rate,
	input  logic [31:0] target_rate,
	input  logic        enable_now,
	output logic [31:0] effective_rate,
	output logic        accepted,
	output logic [15:0] reg_word
);
	localparam int unsigned PW = (NUM_PREDIV > 1) ? $clog2(NUM_PREDIV) : 1;

	logic [31:0] tgt_q;
	logic        en_q;
	logic [32:0] div_full_q;
	logic [7:0]  div_q;
	logic        exact_q;
	logic        dir_q;
	logic [31:0] base_q;
	logic [PW-1:0] p_q;
	logic [1:0]  s_q;
	logic [39:0] cq_q;
	logic [31:0] rnd_y_q;
	logic [25:0] rnd_q_q;
	logic [33:0] best_off_q;
	logic [41:0] best_rate_q;
	logic [PW-1:0] best_p_q;
	logic [1:0]  best_s_q;
	logic        found_q;
	logic        fit_q;

	logic [8:0]  divt;
	logic [8:0]  divb;
	logic        start;
	logic [39:0] dvd;
	logic [31:0] dvs;
	logic        busy;
	logic [39:0] quot;
	logic [31:0] rem;
	logic [41:0] v;
	logic [41:0] c;
	logic [42:0] c_rnd;
	logic [63:0] rnd_prod;
	logic [41:0] off;

	assign divt = 9'(sel_rate(s_q)) * 9'({1'b0, p_q} + 4'd1);
	assign divb = dir_q ? divt - 9'd1 : divt + 9'd1;

	always_comb begin
		dvd = '0;
		dvs = 32'd1;
		case (cmd.div_op)
			DOP_ROUND:  begin dvd = 40'(ref_rate) + 40'(tgt_q[31:1]); dvs = tgt_q; end
			DOP_TRUNC:  begin dvd = 40'(ref_rate); dvs = tgt_q; end
			DOP_BASE:   begin dvd = 40'(ref_rate); dvs = 32'(div_q); end
			DOP_CAND_Q: begin dvd = 40'(base_q); dvs = 32'(divb); end
			DOP_CAND_F: begin dvd = 40'(rem) * 40'(divt); dvs = 32'(divb); end
			default:    begin dvd = '0; dvs = 32'd1; end
		endcase
	end
	assign start = cmd.div_start;

	pllfd_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(start), .dividend(dvd), .divisor(dvs),
		.busy(busy), .quot(quot), .rem(rem)
	);

	// round up to a multiple of 1000: (v+999)/8, then /125 by reciprocal
	assign v        = 42'(cq_q) * 42'(divt) + 42'(quot);
	assign c_rnd    = 43'(v) + 43'(ROUND_STEP - 1);
	assign rnd_prod = 64'(rnd_y_q) * 64'(RECIP_125);
	assign c        = 42'(rnd_q_q) * 42'(ROUND_STEP);
	assign off      = (c > 42'(tgt_q)) ? c - 42'(tgt_q) : 42'(tgt_q) - c;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q <= target_rate;
			en_q  <= enable_now;
		end
		if (cmd.div_op == DOP_ROUND && !busy && !start) div_full_q <= quot[32:0];
		if (cmd.check) begin
			div_q   <= div_full_q[7:0];
			exact_q <= (rem == '0);
			dir_q   <= (quot[32:0] != div_full_q);
		end
		if (cmd.div_op == DOP_BASE && !busy && !start) base_q <= quot[31:0];
		if (cmd.div_op == DOP_CAND_Q && !busy && !start) cq_q <= quot;
		if (cmd.round1) rnd_y_q <= c_rnd[34:3];
		if (cmd.round2) rnd_q_q <= rnd_prod[63:38];
		if (cmd.eval && (off == '0 || off < 42'(best_off_q))) begin
			best_rate_q <= c;
			best_p_q    <= p_q;
			best_s_q    <= s_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0; s_q <= 2'd1; found_q <= 1'b0; fit_q <= 1'b0;
			best_off_q <= '0;
		end else if (cmd.load) begin
			p_q <= '0; s_q <= 2'd1; found_q <= 1'b0; fit_q <= 1'b0;
			best_off_q <= 34'(target_rate);
		end else begin
			if (cmd.eval && (off == '0 || off < 42'(best_off_q))) begin
				best_off_q <= off[33:0];
				found_q    <= 1'b1;
				if (off == '0) fit_q <= 1'b1;
			end
			if (cmd.next_cand) begin
				if (32'(s_q) >= NUM_SEL - 1 || s_q == 2'd3) begin
					s_q <= 2'd1;
					p_q <= p_q + PW'(1);
				end else begin
					s_q <= s_q + 2'd1;
				end
			end
		end
	end

	assign sts.div_busy  = busy || start;
	assign sts.reject    = (tgt_q == '0) || (div_full_q == '0) || (div_full_q > 33'd255);
	assign sts.exact_div = (rem == '0);
	assign sts.last_cand = (32'(p_q) == NUM_PREDIV - 1) &&
		(32'(s_q) >= NUM_SEL - 1 || s_q == 2'd3);
	assign sts.exact_fit = fit_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			effective_rate <= '0;
			accepted       <= 1'b0;
			reg_word       <= '0;
			if (!sts.reject) begin
				if (exact_q) begin
					effective_rate <= base_q;
					accepted       <= (base_q == tgt_q);
					reg_word       <= (base_q == tgt_q) ?
						({en_q, 15'd0} | 16'(div_q)) : 16'd0;
				end else if (found_q) begin
					effective_rate <= (best_rate_q > 42'hFFFFFFFF) ? 32'hFFFFFFFF :
						best_rate_q[31:0];
					accepted       <= (best_rate_q == 42'(tgt_q));
					reg_word       <= (best_rate_q == 42'(tgt_q)) ?
						({en_q, 15'd0} | 16'(div_q) | ROT_BIT | {2'b0, best_s_q, 12'd0} |
						{5'd0, 3'(best_p_q), 8'd0} | (dir_q ? DIR_BIT : 16'd0)) : 16'd0;
				end
			end
		end
	end
endmodule

[rtl/pllfd_ctrl.sv]
module pllfd_ctrl import pllfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  pllfd_sts_t sts,
	output pllfd_cmd_t cmd
);
	pllfd_state_t st_q, st_d;
	logic         base_done_q;
	logic         skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:        if (in_valid) st_d = ST_DIV1;
			ST_DIV1:        st_d = ST_DIV1_WAIT;
			ST_DIV1_WAIT:   if (!sts.div_busy) st_d = ST_DIV2;
			ST_DIV2:        st_d = sts.reject ? ST_FINISH : ST_DIV2_WAIT;
			ST_DIV2_WAIT:   if (!sts.div_busy) st_d = ST_CHECK;
			ST_CHECK:       st_d = ST_CAND_A;
			ST_CAND_A:      st_d = ST_CAND_A_WAIT;
			ST_CAND_A_WAIT: if (!sts.div_busy) begin
				if (base_done_q) st_d = ST_CAND_B;
				else st_d = skip_q ? ST_FINISH : ST_CAND_A;
			end
			ST_CAND_B:      st_d = ST_CAND_B_WAIT;
			ST_CAND_B_WAIT: if (!sts.div_busy) st_d = ST_CAND_R1;
			ST_CAND_R1:     st_d = ST_CAND_R2;
			ST_CAND_R2:     st_d = ST_CAND_EVAL;
			ST_CAND_EVAL:   st_d = sts.last_cand ? ST_FINISH : ST_CAND_A;
			ST_FINISH:      st_d = ST_OUT;
			ST_OUT:         if (!out_stall) st_d = ST_IDLE;
			default:        st_d = ST_IDLE;
		endcase
		if (st_q == ST_CAND_A && sts.exact_fit) st_d = ST_FINISH;
	end

	// first CAND_A pass after CHECK computes base; later passes do candidates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_done_q <= 1'b0;
		else if (st_q == ST_CHECK) base_done_q <= 1'b0;
		else if (st_q == ST_CAND_A_WAIT && !sts.div_busy) base_done_q <= 1'b1;
	end

	// target divides the reference: no search needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) skip_q <= 1'b0;
		else if (st_q == ST_CHECK) skip_q <= sts.exact_div;
	end

	always_comb begin
		cmd = '0;
		cmd.div_op = DOP_NONE;
		case (st_q)
			ST_IDLE: cmd.load = in_valid;
			ST_DIV1: begin cmd.div_op = DOP_ROUND; cmd.div_start = 1'b1; end
			ST_DIV1_WAIT: cmd.div_op = DOP_ROUND;
			ST_DIV2: begin
				cmd.div_op = DOP_TRUNC; cmd.div_start = !sts.reject;
			end
			ST_DIV2_WAIT: cmd.div_op = DOP_TRUNC;
			ST_CHECK: cmd.check = 1'b1;
			ST_CAND_A: begin
				cmd.div_op = base_done_q ? DOP_CAND_Q : DOP_BASE;
				cmd.div_start = !sts.exact_fit;
			end
			ST_CAND_A_WAIT: cmd.div_op = base_done_q ? DOP_CAND_Q : DOP_BASE;
			ST_CAND_B: begin cmd.div_op = DOP_CAND_F; cmd.div_start = 1'b1; end
			ST_CAND_B_WAIT: cmd.div_op = DOP_CAND_F;
			ST_CAND_R1: cmd.round1 = 1'b1;
			ST_CAND_R2: cmd.round2 = 1'b1;
			ST_CAND_EVAL: begin
				cmd.eval = 1'b1;
				cmd.next_cand = 1'b1;
			end
			ST_FINISH: cmd.finish = 1'b1;
			default: ;
		endcase
	end

	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
endmodule

[rtl/pll_fractional_divider_search_unit.sv]
// PLL divider search: one request at a time. Each request runs a shared
// restoring divider up to 3 times for setup and twice per candidate, plus
// rounding and compare in the R1, R2 and EVAL states per candidate, over
// up to NUM_PREDIV*max(1,min(NUM_SEL-1,3)) candidates (24 by default). A
// rejected target stops after the first division; when the target divides
// the reference, no search follows the base division.
module pll_fractional_divider_search_unit import pllfd_pkg::*; #(
	parameter int unsigned NUM_PREDIV = 8,
	parameter int unsigned NUM_SEL    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] target_rate,
	input  logic        enable_now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] effective_rate,
	output logic        accepted,
	output logic [15:0] reg_word
);
	logic [31:0] ref_rate_q;
	pllfd_cmd_t  cmd;
	pllfd_sts_t  sts;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ref_rate_q <= 32'd625000000;
		else if (psel && penable && pwrite && paddr == REG_REF_RATE) ref_rate_q <= pwdata;
	end
	assign prdata = (paddr == REG_REF_RATE) ? ref_rate_q : 32'd0;

	pllfd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	pllfd_datapath #(.NUM_PREDIV(NUM_PREDIV), .NUM_SEL(NUM_SEL)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .ref_rate(ref_rate_q),
		.target_rate(target_rate), .enable_now(enable_now),
		.effective_rate(effective_rate), .accepted(accepted), .reg_word(reg_word)
	);

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");
	a_acc_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> reg_word == 16'd0) else $error("word without accept");
	a_acc_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> effective_rate != 32'd0) else $error("accept on zero");
endmodule

[dv/tb_pll_fractional_divider_search_unit.sv]
module tb_pll_fractional_divider_search_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] rate;
		logic        ok;
		logic [15:0] word;
	} pll_setting_t;

	class pll_setting_board;
		pll_setting_t pending[$];
		logic [31:0]  ref_clk;
		int           mismatches;
		int           checked;

		function new();
			ref_clk = 32'd625000000;
			mismatches = 0;
			checked = 0;
		endfunction

		function logic [63:0] cand_rate(logic [63:0] base, int pd, int sel, bit dir);
			logic [63:0] divt;
			logic [63:0] divb;
			logic [63:0] v;
			divt = ((sel == 1) ? 16 : (sel == 2) ? 8 : 4) * (pd + 1);
			divb = dir ? divt - 1 : divt + 1;
			v = (base / divb) * divt + ((base % divb) * divt) / divb;
			return ((v + 999) / 1000) * 1000;
		endfunction

		function pll_setting_t predict(logic [31:0] tgt, logic en);
			pll_setting_t r;
			logic [63:0]  rf;
			logic [63:0]  t;
			logic [63:0]  div;
			logic [63:0]  eff;
			logic [63:0]  base;
			logic [63:0]  c;
			logic [63:0]  off;
			logic [63:0]  best_off;
			logic [15:0]  word;
			bit           dir;
			bit           found;
			bit           exact;
			int           bp;
			int           bs;
			r.rate = 0;
			r.ok = 0;
			r.word = 0;
			rf = ref_clk;
			t = tgt;
			if (t == 0)
				return r;
			div = (rf + t / 2) / t;
			if (div == 0 || div > 255)
				return r;
			if (rf % t == 0) begin
				eff = rf / div;
				word = {en, 7'd0, div[7:0]};
			end else begin
				base = rf / div;
				dir = (rf / t) != div;
				best_off = t;
				found = 0;
				exact = 0;
				bp = 0;
				bs = 0;
				eff = 0;
				for (int i = 0; i < 8 && !exact; i++) begin
					for (int j = 1; j < 4; j++) begin
						c = cand_rate(base, i, j, dir);
						off = (c > t) ? c - t : t - c;
						if (off == 0 || off < best_off) begin
							best_off = off;
							eff = c;
							bp = i;
							bs = j;
							found = 1;
							if (off == 0) begin
								exact = 1;
								break;
							end
						end
					end
				end
				if (!found)
					return r;
				word = {en, 1'b1, 2'(bs), dir, 3'(bp), div[7:0]};
			end
			r.rate = (eff > 64'hFFFFFFFF) ? 32'hFFFFFFFF : eff[31:0];
			if (eff == t) begin
				r.ok = 1;
				r.word = word;
			end
			return r;
		endfunction

		function void note_request(logic [31:0] tgt, logic en);
			pending.push_back(predict(tgt, en));
		endfunction

		function void check_result(logic [31:0] rate, logic ok, logic [15:0] word);
			pll_setting_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result rate=%0d ok=%0b word=%h", rate, ok, word);
				return;
			end
			e = pending.pop_front();
			if (e.rate !== rate || e.ok !== ok || e.word !== word) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch exp rate=%0d ok=%0b word=%h act rate=%0d ok=%0b word=%h",
						e.rate, e.ok, e.word, rate, ok, word);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] target_rate;
	logic        enable_now;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] effective_rate;
	logic        accepted;
	logic [15:0] reg_word;

	pll_setting_board board;
	int  sent;
	bit  calm;

	localparam logic [1:0] REG_REF_RATE = 2'd0;

	pll_fractional_divider_search_unit u_dut (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#400ms;
		$display("pll_fractional_divider_search_unit verification failed");
		$finish;
	end

	task automatic apb_write(logic [1:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.ref_clk = data;
	endtask

	task automatic send_request(logic [31:0] tgt, logic en);
		while (!calm && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		target_rate <= tgt;
		enable_now <= en;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(tgt, en);
		sent++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (board.pending.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_target(logic [31:0] rf);
		int k;
		logic [31:0] d;
		k = $urandom_range(99);
		d = $urandom_range(255, 1);
		if (k < 30)
			return rf / d;
		if (k < 55)
			return (rf / d) + $urandom_range(2000) - 1000;
		if (k < 75)
			return ((rf / d) / 1000) * 1000;
		if (k < 85)
			return $urandom_range(rf / 200 + 1);
		return $urandom;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result(effective_rate, accepted, reg_word);
			out_stall <= !calm && ($urandom_range(99) < 15);
		end
	end

	initial begin
		logic [31:0] refs[6];
		board = new();
		sent = 0;
		calm = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		target_rate = '0;
		enable_now = 1'b0;
		out_stall = 1'b0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(32'd0, 1'b1);
		send_request(32'd625000000, 1'b1);
		send_request(32'd312500000, 1'b0);
		send_request(32'd2450980, 1'b1);
		send_request(32'd2000000, 1'b1);
		send_request(32'd100000000, 1'b1);
		send_request(32'd150000000, 1'b0);
		send_request(32'd624999999, 1'b1);
		send_request(32'hFFFFFFFF, 1'b1);
		send_request(32'd1, 1'b0);
		send_request(32'd1000, 1'b1);
		send_request(32'd250000, 1'b0);
		send_request(32'd2451000, 1'b1);
		drain();
		apb_write(REG_REF_RATE, 32'hFFFFFFFF);
		send_request(32'hFFFFFFFF, 1'b1);
		send_request(32'h7FFFFFFF, 1'b1);
		send_request(32'd4294000000, 1'b0);
		send_request(32'd3000000000, 1'b1);
		drain();
		apb_write(REG_REF_RATE, 32'd1);
		send_request(32'd1, 1'b1);
		send_request(32'd2, 1'b0);
		send_request(32'd0, 1'b1);
		drain();

		refs = '{32'd625000000, 32'd1000000000, 32'hFFFFFFFF, 32'd25000000,
			32'd1, 32'd0};
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5)
				refs[5] = $urandom | 32'd1;
			apb_write(REG_REF_RATE, refs[ph]);
			calm = (ph == 2);
			for (int n = 0; n < 100; n++) begin
				send_request(pick_target(refs[ph]), 1'($urandom));
				if (n == 50)
					drain();
			end
			drain();
		end
		calm = 0;

		$display("covered %0d requests over several reference rates, %0d results checked",
			sent, board.checked);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("pll_fractional_divider_search_unit verification clean");
		end else begin
			$display("%0d mismatches, %0d results missing", board.mismatches,
				board.pending.size());
			$display("pll_fractional_divider_search_unit verification failed");
		end
		$finish;
	end
endmodule

[filelist.f]
rtl/pllfd_pkg.sv
rtl/pllfd_divider.sv
rtl/pllfd_datapath.sv
rtl/pllfd_ctrl.sv
rtl/pll_fractional_divider_search_unit.sv
dv/tb_pll_fractional_divider_search_unit.sv
